>>> hw/rtl/twhsm_pkg.sv
// Package with the types, codes and helper functions of the two-wire sensor master.
package twhsm_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SHORT_TICKS   = 3'd0;
    localparam logic [2:0] CFG_LONG_TICKS    = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd2;
    localparam logic [2:0] CFG_CRC_ENABLE    = 3'd3;
    localparam logic [2:0] CFG_STATUS_MASK   = 3'd4;

    // Operation codes.
    localparam logic [2:0] OP_MEAS_TEMP    = 3'd0;
    localparam logic [2:0] OP_MEAS_HUMI    = 3'd1;
    localparam logic [2:0] OP_READ_STATUS  = 3'd2;
    localparam logic [2:0] OP_WRITE_STATUS = 3'd3;
    localparam logic [2:0] OP_RESET        = 3'd4;

    // Sensor command bytes.
    localparam logic [7:0] CMD_MEAS_TEMP    = 8'h03;
    localparam logic [7:0] CMD_MEAS_HUMI    = 8'h05;
    localparam logic [7:0] CMD_READ_STATUS  = 8'h07;
    localparam logic [7:0] CMD_WRITE_STATUS = 8'h06;
    localparam logic [7:0] CMD_SOFT_RESET   = 8'h1E;

    // Result status codes.
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_NO_ACK  = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;
    localparam logic [1:0] ERR_CRC     = 2'd3;

    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [3:0] RESET_CLOCKS = 4'd9;
    localparam logic [3:0] BYTE_BITS    = 4'd8;

    // Reset values of the configuration registers.
    localparam logic [15:0] SHORT_TICKS_RST   = 16'd50;
    localparam logic [15:0] LONG_TICKS_RST    = 16'd100;
    localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd720000;
    localparam logic [7:0]  STATUS_MASK_RST   = 8'd7;

    typedef enum logic [4:0] {
        PH_IDLE, PH_RST_PRE, PH_RST_HI, PH_RST_LO,
        PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5, PH_ST6,
        PH_PB_SET, PH_PB_HI, PH_PB_LO, PH_PA_HI, PH_PA_END,
        PH_WAIT, PH_GB_HI, PH_GB_LO, PH_GA_SET, PH_GA_HI, PH_GA_LO
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic [2:0] opcode;
        logic [7:0] write_value;
        logic       data_in;
    } t_in_item;

    typedef struct packed {
        logic        sck;
        logic        data_oe;
        logic        data_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic [1:0]  status_code;
    } t_out_item;

    // Command byte of an operation; unknown codes give zero.
    function automatic logic [7:0] cmd_code(input logic [2:0] op);
        logic [7:0] c;
        case (op)
            OP_MEAS_TEMP:    c = CMD_MEAS_TEMP;
            OP_MEAS_HUMI:    c = CMD_MEAS_HUMI;
            OP_READ_STATUS:  c = CMD_READ_STATUS;
            OP_WRITE_STATUS: c = CMD_WRITE_STATUS;
            OP_RESET:        c = CMD_SOFT_RESET;
            default:         c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // One byte through the CRC-8, MSB first.
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc ^ v;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Phases timed by the long pulse length.
    function automatic logic is_long(input t_phase p);
        return (p == PH_RST_PRE) || (p == PH_RST_HI) || (p == PH_RST_LO) ||
               (p == PH_ST3) || (p == PH_PB_HI) || (p == PH_PA_HI) || (p == PH_GA_HI);
    endfunction

    // Received bytes before the optional CRC byte.
    function automatic logic [1:0] data_bytes(input logic [2:0] op);
        return (op == OP_READ_STATUS) ? 2'd1 : 2'd2;
    endfunction

    // True while receiving the final byte of the transfer.
    function automatic logic last_byte(input logic [1:0] idx, input logic [2:0] op,
                                       input logic crc_en);
        logic [1:0] lim;
        lim = ((op == OP_READ_STATUS) ? 2'd0 : 2'd1) + {1'b0, crc_en};
        return idx >= lim;
    endfunction

endpackage

>>> hw/rtl/two_wire_humidity_sensor_master_core.sv
// Tick-level two-wire sensor master: pin sequencer, CRC-8 check and result register.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_in  (t_in_item, one tick)
//  output    out        o_out_valid / i_out_stall  o_out (t_out_item, pins and result)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One item is one tick of the pin sequencer; a new item is accepted every cycle
// unless the input is stalled, set by the single state update ahead of the
// result register. Each accepted item gives one result item in the next cycle.
// A stalled result is held in the result register, and the input is stalled only
// while that register is full and the output side stalls.
// Reset (synchronous, active low) returns to idle with the default configuration.
module two_wire_humidity_sensor_master_core
    import twhsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out
);

    logic [15:0] r_short_ticks;
    logic [15:0] r_long_ticks;
    logic [23:0] r_timeout_ticks;
    logic        r_crc_enable;
    logic [7:0]  r_status_mask;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_held_op, n_held_op;
    logic [15:0] r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_status_copy, n_status_copy;
    logic [15:0] r_value, n_value;
    logic [23:0] r_wait, n_wait;
    logic [1:0]  r_error, n_error;
    logic        n_done;

    t_out_item   r_out, n_out;
    logic        r_out_valid;

    logic        in_accept;
    logic        phase_end;
    logic [15:0] tick_inc;
    logic [15:0] dur;
    logic [23:0] wait_inc;
    logic [23:0] wait_lim;
    logic        dout;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks   <= SHORT_TICKS_RST;
            r_long_ticks    <= LONG_TICKS_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
            r_crc_enable    <= 1'b1;
            r_status_mask   <= STATUS_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_TICKS:   r_short_ticks   <= i_cfg_data[15:0];
                CFG_LONG_TICKS:    r_long_ticks    <= i_cfg_data[15:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                CFG_CRC_ENABLE:    r_crc_enable    <= i_cfg_data[0];
                CFG_STATUS_MASK:   r_status_mask   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Next state for one tick.
    always_comb begin
        n_phase       = r_phase;
        n_held_op     = r_held_op;
        n_tick        = r_tick;
        n_bit         = r_bit;
        n_byte_idx    = r_byte_idx;
        n_shift       = r_shift;
        n_crc         = r_crc;
        n_status_copy = r_status_copy;
        n_value       = r_value;
        n_wait        = r_wait;
        n_error       = r_error;
        n_done        = 1'b0;
        phase_end     = 1'b0;

        tick_inc = r_tick + 16'd1;
        wait_inc = r_wait + 24'd1;
        dur      = is_long(r_phase) ? r_long_ticks : r_short_ticks;
        if (dur == 16'd0) begin
            dur = 16'd1;
        end
        wait_lim = (r_timeout_ticks == 24'd0) ? 24'd1 : r_timeout_ticks;

        case (r_phase)
            PH_IDLE: begin
                if (i_in.start_req && i_in.opcode <= OP_RESET) begin
                    n_held_op  = i_in.opcode;
                    n_error    = ERR_OK;
                    n_value    = '0;
                    n_tick     = '0;
                    n_bit      = '0;
                    n_byte_idx = '0;
                    n_wait     = '0;
                    n_shift    = '0;
                    if (i_in.opcode <= OP_READ_STATUS) begin
                        n_crc = rev8(r_status_copy & r_status_mask);
                    end
                    if (i_in.opcode == OP_WRITE_STATUS) begin
                        n_status_copy = i_in.write_value & r_status_mask;
                    end
                    if (i_in.opcode == OP_RESET) begin
                        n_status_copy = '0;
                        n_phase       = PH_RST_PRE;
                    end else begin
                        n_phase = PH_ST0;
                    end
                end
            end
            PH_WAIT: begin
                // The sensor pulls data low when the measurement is ready.
                if (!i_in.data_in) begin
                    n_tick     = '0;
                    n_byte_idx = '0;
                    n_bit      = '0;
                    n_shift    = '0;
                    n_phase    = PH_GB_HI;
                end else begin
                    n_wait = wait_inc;
                    if (wait_inc >= wait_lim) begin
                        n_error = ERR_TIMEOUT;
                        n_value = '0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            default: begin
                n_tick = tick_inc;
                if (tick_inc >= dur) begin
                    n_tick    = '0;
                    phase_end = 1'b1;
                end
            end
        endcase

        // Work done at the end of a timed phase.
        if (phase_end) begin
            case (r_phase)
                PH_RST_PRE: begin
                    n_bit   = '0;
                    n_phase = PH_RST_HI;
                end
                PH_RST_HI: n_phase = PH_RST_LO;
                PH_RST_LO: begin
                    n_bit   = r_bit + 4'd1;
                    n_phase = (n_bit >= RESET_CLOCKS) ? PH_ST0 : PH_RST_HI;
                end
                PH_ST0: n_phase = PH_ST1;
                PH_ST1: n_phase = PH_ST2;
                PH_ST2: n_phase = PH_ST3;
                PH_ST3: n_phase = PH_ST4;
                PH_ST4: n_phase = PH_ST5;
                PH_ST5: n_phase = PH_ST6;
                PH_ST6: begin
                    n_shift    = cmd_code(r_held_op);
                    n_bit      = '0;
                    n_byte_idx = '0;
                    n_phase    = PH_PB_SET;
                end
                PH_PB_SET: n_phase = PH_PB_HI;
                PH_PB_HI:  n_phase = PH_PB_LO;
                PH_PB_LO: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    n_phase = (n_bit >= BYTE_BITS) ? PH_PA_HI : PH_PB_SET;
                end
                PH_PA_HI: begin
                    if (i_in.data_in) begin
                        n_error = ERR_NO_ACK;
                    end
                    n_phase = PH_PA_END;
                end
                PH_PA_END: begin
                    // A byte has been sent: decide what follows it.
                    if (r_error != ERR_OK) begin
                        n_value = (r_held_op == OP_READ_STATUS) ? 16'h00FF : 16'h0000;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else if (r_byte_idx != 2'd0) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        if (r_held_op <= OP_READ_STATUS) begin
                            n_crc = crc_update(r_crc, cmd_code(r_held_op));
                        end
                        case (r_held_op)
                            OP_MEAS_TEMP, OP_MEAS_HUMI: begin
                                n_wait  = '0;
                                n_phase = PH_WAIT;
                            end
                            OP_READ_STATUS: begin
                                n_byte_idx = '0;
                                n_bit      = '0;
                                n_shift    = '0;
                                n_phase    = PH_GB_HI;
                            end
                            OP_WRITE_STATUS: begin
                                n_shift    = r_status_copy;
                                n_byte_idx = 2'd1;
                                n_bit      = '0;
                                n_phase    = PH_PB_SET;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end
                        endcase
                    end
                end
                PH_GB_HI: begin
                    n_shift = {r_shift[6:0], i_in.data_in};
                    n_phase = PH_GB_LO;
                end
                PH_GB_LO: begin
                    n_bit   = r_bit + 4'd1;
                    n_phase = (n_bit >= BYTE_BITS) ? PH_GA_SET : PH_GB_HI;
                end
                PH_GA_SET: n_phase = PH_GA_HI;
                PH_GA_HI:  n_phase = PH_GA_LO;
                PH_GA_LO: begin
                    // A byte has been received: data bytes feed the CRC, the
                    // last one may be the CRC itself.
                    if (r_byte_idx < data_bytes(r_held_op)) begin
                        n_value = {r_value[7:0], r_shift};
                        n_crc   = crc_update(r_crc, r_shift);
                    end else if (rev8(r_shift) != r_crc) begin
                        n_error = ERR_CRC;
                        n_value = (r_held_op == OP_READ_STATUS) ? 16'h00FF : 16'hFFFF;
                    end
                    if (last_byte(r_byte_idx, r_held_op, r_crc_enable)) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_byte_idx = r_byte_idx + 2'd1;
                        n_bit      = '0;
                        n_shift    = '0;
                        n_phase    = PH_GB_HI;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        // Pin levels and result for the state after this tick.
        n_out = '0;
        dout  = 1'b0;
        case (n_phase)
            PH_RST_PRE, PH_RST_LO, PH_ST0, PH_ST6: begin
                n_out.data_oe = 1'b1;
                dout          = 1'b1;
            end
            PH_RST_HI, PH_ST1, PH_ST5: begin
                n_out.sck     = 1'b1;
                n_out.data_oe = 1'b1;
                dout          = 1'b1;
            end
            PH_ST2, PH_ST4: begin
                n_out.sck     = 1'b1;
                n_out.data_oe = 1'b1;
            end
            PH_ST3: n_out.data_oe = 1'b1;
            PH_PB_SET, PH_PB_LO: begin
                n_out.data_oe = 1'b1;
                dout          = n_shift[7];
            end
            PH_PB_HI: begin
                n_out.sck     = 1'b1;
                n_out.data_oe = 1'b1;
                dout          = n_shift[7];
            end
            PH_PA_HI, PH_PA_END, PH_GB_HI: n_out.sck = 1'b1;
            PH_GA_SET, PH_GA_LO: begin
                n_out.data_oe = 1'b1;
                dout          = last_byte(n_byte_idx, n_held_op, r_crc_enable);
            end
            PH_GA_HI: begin
                n_out.sck     = 1'b1;
                n_out.data_oe = 1'b1;
                dout          = last_byte(n_byte_idx, n_held_op, r_crc_enable);
            end
            default: ;
        endcase
        n_out.data_out    = n_out.data_oe && dout;
        n_out.busy_res    = (n_phase != PH_IDLE);
        n_out.done_res    = n_done;
        n_out.read_value  = n_value;
        n_out.status_code = n_error;
    end

    // Sequencer state, advanced once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_held_op     <= '0;
            r_tick        <= '0;
            r_bit         <= '0;
            r_byte_idx    <= '0;
            r_shift       <= '0;
            r_crc         <= '0;
            r_status_copy <= '0;
            r_value       <= '0;
            r_wait        <= '0;
            r_error       <= '0;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_held_op     <= n_held_op;
            r_tick        <= n_tick;
            r_bit         <= n_bit;
            r_byte_idx    <= n_byte_idx;
            r_shift       <= n_shift;
            r_crc         <= n_crc;
            r_status_copy <= n_status_copy;
            r_value       <= n_value;
            r_wait        <= n_wait;
            r_error       <= n_error;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    // Every accepted item leaves a result behind it.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item did not produce a result");

    // A pending done result means the sequencer has already returned to idle.
    a_done_means_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> (r_phase == PH_IDLE))
        else $error("done reported while sequencer still active");

    // The ready wait is only entered by a measurement.
    a_wait_only_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_held_op == OP_MEAS_TEMP || r_held_op == OP_MEAS_HUMI))
        else $error("ready wait outside a measurement");

    // At most a data pair and a CRC byte are received.
    a_byte_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_byte_idx != 2'd3))
        else $error("byte index out of range");

endmodule
